@@ hw/rtl/shbe_pkg.sv @@
// ----------------------------------------------------------------------------
// shbe_pkg
// types, tables and helper functions shared by the hash engine modules
// ----------------------------------------------------------------------------
package shbe_pkg;

	localparam int unsigned Rounds = 12;

	typedef logic [63:0]       word_t;
	typedef logic [511:0]      blk_t;
	typedef logic [3:0]        rnd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_KEY,
		ST_ROUND_TXT,
		ST_ROUND_KEY,
		ST_FINISH,
		ST_ADD,
		ST_EMIT
	} state_t;

	// which compression pass is running
	typedef enum logic [1:0] {
		PASS_MSG,
		PASS_CNT,
		PASS_SUM
	} pass_t;

	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_KEY,
		CMD_TXT,
		CMD_RKEY,
		CMD_FIN,
		CMD_ADD,
		CMD_NEXT
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t op;
		pass_t   pass;
		rnd_t    rnd;
	} cmd_t;

	typedef struct packed {
		logic is_final;
	} status_t;

	function automatic logic [7:0] pi_sbox(input logic [7:0] a);
		logic [7:0] t [256];
		t = '{
		8'hFC,8'hEE,8'hDD,8'h11,8'hCF,8'h6E,8'h31,8'h16,8'hFB,8'hC4,8'hFA,8'hDA,8'h23,8'hC5,8'h04,8'h4D,
		8'hE9,8'h77,8'hF0,8'hDB,8'h93,8'h2E,8'h99,8'hBA,8'h17,8'h36,8'hF1,8'hBB,8'h14,8'hCD,8'h5F,8'hC1,
		8'hF9,8'h18,8'h65,8'h5A,8'hE2,8'h5C,8'hEF,8'h21,8'h81,8'h1C,8'h3C,8'h42,8'h8B,8'h01,8'h8E,8'h4F,
		8'h05,8'h84,8'h02,8'hAE,8'hE3,8'h6A,8'h8F,8'hA0,8'h06,8'h0B,8'hED,8'h98,8'h7F,8'hD4,8'hD3,8'h1F,
		8'hEB,8'h34,8'h2C,8'h51,8'hEA,8'hC8,8'h48,8'hAB,8'hF2,8'h2A,8'h68,8'hA2,8'hFD,8'h3A,8'hCE,8'hCC,
		8'hB5,8'h70,8'h0E,8'h56,8'h08,8'h0C,8'h76,8'h12,8'hBF,8'h72,8'h13,8'h47,8'h9C,8'hB7,8'h5D,8'h87,
		8'h15,8'hA1,8'h96,8'h29,8'h10,8'h7B,8'h9A,8'hC7,8'hF3,8'h91,8'h78,8'h6F,8'h9D,8'h9E,8'hB2,8'hB1,
		8'h32,8'h75,8'h19,8'h3D,8'hFF,8'h35,8'h8A,8'h7E,8'h6D,8'h54,8'hC6,8'h80,8'hC3,8'hBD,8'h0D,8'h57,
		8'hDF,8'hF5,8'h24,8'hA9,8'h3E,8'hA8,8'h43,8'hC9,8'hD7,8'h79,8'hD6,8'hF6,8'h7C,8'h22,8'hB9,8'h03,
		8'hE0,8'h0F,8'hEC,8'hDE,8'h7A,8'h94,8'hB0,8'hBC,8'hDC,8'hE8,8'h28,8'h50,8'h4E,8'h33,8'h0A,8'h4A,
		8'hA7,8'h97,8'h60,8'h73,8'h1E,8'h00,8'h62,8'h44,8'h1A,8'hB8,8'h38,8'h82,8'h64,8'h9F,8'h26,8'h41,
		8'hAD,8'h45,8'h46,8'h92,8'h27,8'h5E,8'h55,8'h2F,8'h8C,8'hA3,8'hA5,8'h7D,8'h69,8'hD5,8'h95,8'h3B,
		8'h07,8'h58,8'hB3,8'h40,8'h86,8'hAC,8'h1D,8'hF7,8'h30,8'h37,8'h6B,8'hE4,8'h88,8'hD9,8'hE7,8'h89,
		8'hE1,8'h1B,8'h83,8'h49,8'h4C,8'h3F,8'hF8,8'hFE,8'h8D,8'h53,8'hAA,8'h90,8'hCA,8'hD8,8'h85,8'h61,
		8'h20,8'h71,8'h67,8'hA4,8'h2D,8'h2B,8'h09,8'h5B,8'hCB,8'h9B,8'h25,8'hD0,8'hBE,8'hE5,8'h6C,8'h52,
		8'h59,8'hA6,8'h74,8'hD2,8'hE6,8'hF4,8'hB4,8'hC0,8'hD1,8'h66,8'hAF,8'hC2,8'h39,8'h4B,8'h63,8'hB6};
		return t[a];
	endfunction

	function automatic word_t lin_row(input logic [5:0] k);
		word_t t [64];
		t = '{
		64'h8e20faa72ba0b470,64'h47107ddd9b505a38,64'had08b0e0c3282d1c,64'hd8045870ef14980e,
		64'h6c022c38f90a4c07,64'h3601161cf205268d,64'h1b8e0b0e798c13c8,64'h83478b07b2468764,
		64'ha011d380818e8f40,64'h5086e740ce47c920,64'h2843fd2067adea10,64'h14aff010bdd87508,
		64'h0ad97808d06cb404,64'h05e23c0468365a02,64'h8c711e02341b2d01,64'h46b60f011a83988e,
		64'h90dab52a387ae76f,64'h486dd4151c3dfdb9,64'h24b86a840e90f0d2,64'h125c354207487869,
		64'h092e94218d243cba,64'h8a174a9ec8121e5d,64'h4585254f64090fa0,64'haccc9ca9328a8950,
		64'h9d4df05d5f661451,64'hc0a878a0a1330aa6,64'h60543c50de970553,64'h302a1e286fc58ca7,
		64'h18150f14b9ec46dd,64'h0c84890ad27623e0,64'h0642ca05693b9f70,64'h0321658cba93c138,
		64'h86275df09ce8aaa8,64'h439da0784e745554,64'hafc0503c273aa42a,64'hd960281e9d1d5215,
		64'he230140fc0802984,64'h71180a8960409a42,64'hb60c05ca30204d21,64'h5b068c651810a89e,
		64'h456c34887a3805b9,64'hac361a443d1c8cd2,64'h561b0d22900e4669,64'h2b838811480723ba,
		64'h9bcf4486248d9f5d,64'hc3e9224312c8c1a0,64'heffa11af0964ee50,64'hf97d86d98a327728,
		64'he4fa2054a80b329c,64'h727d102a548b194e,64'h39b008152acb8227,64'h9258048415eb419d,
		64'h492c024284fbaec0,64'haa16012142f35760,64'h550b8e9e21f7a530,64'ha48b474f9ef5dc18,
		64'h70a6a56e2440598e,64'h3853dc371220a247,64'h1ca76e95091051ad,64'h0edd37c48a08a6d8,
		64'h07e095624504536c,64'h8d70c431ac02a736,64'hc83862965601dd1b,64'h641c314b2b8ee083};
		return t[k];
	endfunction

	function automatic blk_t round_const(input rnd_t r);
		blk_t t [12];
		t = '{
		{64'hb1085bda1ecadae9,64'hebcb2f81c0657c1f,64'h2f6a76432e45d016,64'h714eb88d7585c4fc,
		 64'h4b7ce09192676901,64'ha2422a08a460d315,64'h05767436cc744d23,64'hdd806559f2a64507},
		{64'h6fa3b58aa99d2f1a,64'h4fe39d460f70b5d7,64'hf3feea720a232b98,64'h61d55e0f16b50131,
		 64'h9ab5176b12d69958,64'h5cb561c2db0aa7ca,64'h55dda21bd7cbcd56,64'he679047021b19bb7},
		{64'hf574dcac2bce2fc7,64'h0a39fc286a3d8435,64'h06f15e5f529c1f8b,64'hf2ea7514b1297b7b,
		 64'hd3e20fe490359eb1,64'hc1c93a376062db09,64'hc2b6f443867adb31,64'h991e96f50aba0ab2},
		{64'hef1fdfb3e81566d2,64'hf948e1a05d71e4dd,64'h488e857e335c3c7d,64'h9d721cad685e353f,
		 64'ha9d72c82ed03d675,64'hd8b71333935203be,64'h3453eaa193e837f1,64'h220cbebc84e3d12e},
		{64'h4bea6bacad474799,64'h9a3f410c6ca92363,64'h7f151c1f1686104a,64'h359e35d7800fffbd,
		 64'hbfcd1747253af5a3,64'hdfff00b723271a16,64'h7a56a27ea9ea63f5,64'h601758fd7c6cfe57},
		{64'hae4faeae1d3ad3d9,64'h6fa4c33b7a3039c0,64'h2d66c4f95142a46c,64'h187f9ab49af08ec6,
		 64'hcffaa6b71c9ab7b4,64'h0af21f66c2bec6b6,64'hbf71c57236904f35,64'hfa68407a46647d6e},
		{64'hf4c70e16eeaac5ec,64'h51ac86febf240954,64'h399ec6c7e6bf87c9,64'hd3473e33197a93c9,
		 64'h0992abc52d822c37,64'h06476983284a0504,64'h3517454ca23c4af3,64'h8886564d3a14d493},
		{64'h9b1f5b424d93c9a7,64'h03e7aa020c6e4141,64'h4eb7f8719c36de1e,64'h89b4443b4ddbc49a,
		 64'hf4892bcb929b0690,64'h69d18d2bd1a5c42f,64'h36acc2355951a8d9,64'ha47f0dd4bf02e71e},
		{64'h378f5a541631229b,64'h944c9ad8ec165fde,64'h3a7d3a1b25894224,64'h3cd955b7e00d0984,
		 64'h800a440bdbb2ceb1,64'h7b2b8a9aa6079c54,64'h0e38dc92cb1f2a60,64'h7261445183235adb},
		{64'habbedea680056f52,64'h382ae548b2e4f3f3,64'h8941e71cff8a78db,64'h1fffe18a1b336103,
		 64'h9fe76702af69334b,64'h7a1e6c303b7652f4,64'h3698fad1153bb6c3,64'h74b4c7fb98459ced},
		{64'h7bcd9ed0efc889fb,64'h3002c6cd635afe94,64'hd8fa6bbbebab0761,64'h2001802114846679,
		 64'h8a1d71efea48b9ca,64'hefbacd1d7d476e98,64'hdea2594ac06fd85d,64'h6bcaa4cd81f32d1b},
		{64'h378ee767f11631ba,64'hd21380b00449b17a,64'hcda43c32bcdf1d77,64'hf82012d430219f9b,
		 64'h5d80ef9d1891cc86,64'he71da4aa88e12852,64'hfaf417d5d9b21b99,64'h48bc924af11bd720}};
		return (r < rnd_t'(Rounds)) ? t[r] : '0;
	endfunction

	function automatic word_t lin_map(input word_t v);
		word_t r;
		r = '0;
		for (int b = 0; b < 64; b++)
			if (v[b]) r ^= lin_row(6'(63 - b));
		return r;
	endfunction

	// one LPS transform on a xor b
	function automatic blk_t xlps(input blk_t a, input blk_t b);
		blk_t x;
		blk_t y;
		word_t t;
		x = a ^ b;
		y = '0;
		for (int i = 0; i < 8; i++) begin
			for (int j = 0; j < 8; j++)
				t[8*j +: 8] = pi_sbox(x[64*j + 8*i +: 8]);
			y[64*i +: 64] = lin_map(t);
		end
		return y;
	endfunction

endpackage

@@ hw/rtl/streebog_hash_engine_unit.sv @@
// ----------------------------------------------------------------------------
// streebog_hash_engine_unit
// streebog 256/512 hash over 512-bit blocks, one block per beat
// ----------------------------------------------------------------------------
// plain block: load, key, 12 rounds of two shared-lps steps, finish, add
// final block: counter and sum passes follow, then 4 or 8 output beats
// one block at a time; s_tready is high only while the sequencer is idle
// arst_n clears the sequencer, digest_size and the hash state (512-bit iv)
module streebog_hash_engine_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic         cfg_data,      // digest_size
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [519:0] s_tdata,       // tail_length, msg_word_0..7, zero pad
	input  logic [1:0]   s_tuser,       // first, final_req
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [71:0]  m_tdata,       // digest_word, word_index, zero pad
	output logic         m_tlast
);
	logic              size_q;
	logic              busy, emitting, emit_done;
	shbe_pkg::cmd_t    cmd;
	shbe_pkg::status_t stat;
	logic [63:0]       dword;
	logic [2:0]        widx;

	// digest size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) size_q <= 1'b0;
		else if (cfg_valid && cfg_ready) size_q <= cfg_data;
	end
	assign cfg_ready = 1'b1;

	assign s_tready = !busy;
	assign m_tvalid = emitting;
	assign m_tdata  = {5'd0, widx, dword};

	shbe_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(s_tvalid && s_tready), .stat(stat),
		.emit_done(emit_done), .busy(busy), .emitting(emitting), .cmd(cmd)
	);

	shbe_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .digest_size(size_q),
		.first(s_tuser[0]), .final_req(s_tuser[1]), .tail_length(s_tdata[5:0]),
		.msg(s_tdata[517:6]), .out_take(m_tvalid && m_tready), .stat(stat),
		.emit_done(emit_done), .digest_word(dword), .word_index(widx), .last(m_tlast)
	);

	a_out_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready) else $error("output while accepting");
	a_last_end: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> !m_tvalid) else $error("beat after last");
	a_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready) else $error("accept while busy");
endmodule

@@ hw/rtl/shbe_ctrl.sv @@
// ----------------------------------------------------------------------------
// shbe_ctrl
// sequencer for the compression passes and digest output
// ----------------------------------------------------------------------------
module shbe_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  shbe_pkg::status_t stat,
	input  logic              emit_done,
	output logic              busy,
	output logic              emitting,
	output shbe_pkg::cmd_t    cmd
);
	shbe_pkg::state_t state_q, state_d;
	shbe_pkg::pass_t  pass_q, pass_d;
	shbe_pkg::rnd_t   rnd_q, rnd_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= shbe_pkg::ST_IDLE;
			pass_q  <= shbe_pkg::PASS_MSG;
			rnd_q   <= '0;
		end else begin
			state_q <= state_d;
			pass_q  <= pass_d;
			rnd_q   <= rnd_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		pass_d   = pass_q;
		rnd_d    = rnd_q;
		cmd      = '{op: shbe_pkg::CMD_NONE, pass: pass_q, rnd: rnd_q};
		busy     = (state_q != shbe_pkg::ST_IDLE);
		emitting = (state_q == shbe_pkg::ST_EMIT);
		unique case (state_q)
			shbe_pkg::ST_IDLE: begin
				if (start) begin
					cmd.op  = shbe_pkg::CMD_LOAD;
					pass_d  = shbe_pkg::PASS_MSG;
					state_d = shbe_pkg::ST_KEY;
				end
			end
			shbe_pkg::ST_KEY: begin
				cmd.op  = shbe_pkg::CMD_KEY;
				rnd_d   = '0;
				state_d = shbe_pkg::ST_ROUND_TXT;
			end
			shbe_pkg::ST_ROUND_TXT: begin
				cmd.op  = shbe_pkg::CMD_TXT;
				state_d = shbe_pkg::ST_ROUND_KEY;
			end
			shbe_pkg::ST_ROUND_KEY: begin
				cmd.op = shbe_pkg::CMD_RKEY;
				rnd_d  = rnd_q + 1'b1;
				if (rnd_q == shbe_pkg::rnd_t'(shbe_pkg::Rounds - 1))
					state_d = shbe_pkg::ST_FINISH;
				else
					state_d = shbe_pkg::ST_ROUND_TXT;
			end
			shbe_pkg::ST_FINISH: begin
				cmd.op = shbe_pkg::CMD_FIN;
				priority if (pass_q == shbe_pkg::PASS_MSG)
					state_d = shbe_pkg::ST_ADD;
				else if (pass_q == shbe_pkg::PASS_CNT) begin
					pass_d  = shbe_pkg::PASS_SUM;
					state_d = shbe_pkg::ST_KEY;
				end else
					state_d = shbe_pkg::ST_EMIT;
			end
			shbe_pkg::ST_ADD: begin
				cmd.op = shbe_pkg::CMD_ADD;
				if (stat.is_final) begin
					pass_d  = shbe_pkg::PASS_CNT;
					state_d = shbe_pkg::ST_KEY;
				end else
					state_d = shbe_pkg::ST_IDLE;
			end
			shbe_pkg::ST_EMIT: begin
				cmd.op = shbe_pkg::CMD_NEXT;
				if (emit_done) state_d = shbe_pkg::ST_IDLE;
			end
			default: state_d = shbe_pkg::ST_IDLE;
		endcase
	end

	a_round_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == shbe_pkg::ST_ROUND_TXT) |-> (rnd_q < shbe_pkg::rnd_t'(shbe_pkg::Rounds)))
		else $error("round index out of range");
	a_add_after_fin: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == shbe_pkg::ST_ADD) |-> ($past(state_q) == shbe_pkg::ST_FINISH))
		else $error("add without finished pass");
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == shbe_pkg::ST_EMIT) |=>
		(state_q == shbe_pkg::ST_EMIT || state_q == shbe_pkg::ST_IDLE))
		else $error("restart while emitting");
endmodule

@@ hw/rtl/shbe_datapath.sv @@
// ----------------------------------------------------------------------------
// shbe_datapath
// state registers, one shared lps unit and the 512-bit adders
// ----------------------------------------------------------------------------
module shbe_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  shbe_pkg::cmd_t    cmd,
	input  logic              digest_size,
	input  logic              first,
	input  logic              final_req,
	input  logic [5:0]        tail_length,
	input  shbe_pkg::blk_t    msg,
	input  logic              out_take,
	output shbe_pkg::status_t stat,
	output logic              emit_done,
	output logic [63:0]       digest_word,
	output logic [2:0]        word_index,
	output logic              last
);
	shbe_pkg::blk_t h_q, n_q, s_q;      // stored message state
	shbe_pkg::blk_t wh_q, wn_q, ws_q;   // working copy for the closing run
	shbe_pkg::blk_t m_q, key_q, txt_q;
	logic           fin_q;
	logic [5:0]     tl_q;
	logic [2:0]     idx_q;
	logic           small_q;

	shbe_pkg::blk_t lps_a, lps_b, lps_y, add_a, add_b, add_y, h_cur, n_cur, mpad;

	always_comb begin
		mpad = msg;
		for (int i = 0; i < 64; i++) begin
			if (final_req && (i == int'(tail_length))) mpad[8*i +: 8] = 8'h01;
			else if (final_req && (i > int'(tail_length))) mpad[8*i +: 8] = 8'h00;
		end
	end

	assign h_cur = (cmd.pass == shbe_pkg::PASS_MSG && !fin_q) ? h_q : wh_q;
	assign n_cur = (cmd.pass == shbe_pkg::PASS_MSG) ? (fin_q ? wn_q : n_q) : '0;

	always_comb begin
		lps_a = key_q;
		lps_b = shbe_pkg::round_const(cmd.rnd);
		unique case (cmd.op)
			shbe_pkg::CMD_KEY: begin lps_a = h_cur; lps_b = n_cur; end
			shbe_pkg::CMD_TXT: begin lps_a = txt_q; lps_b = key_q; end
			default: ;
		endcase
	end
	assign lps_y = shbe_pkg::xlps(lps_a, lps_b);

	// counter add and sum add both land in the single add step
	assign add_a = fin_q ? wn_q : n_q;
	assign add_b = {500'd0, (fin_q ? {3'd0, tl_q, 3'd0} : 12'd512)};
	assign add_y = add_a + add_b;

	shbe_pkg::blk_t sum_y;
	assign sum_y = (fin_q ? ws_q : s_q) + m_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q     <= '0;
			n_q     <= '0;
			s_q     <= '0;
			wh_q    <= '0;
			wn_q    <= '0;
			ws_q    <= '0;
			m_q     <= '0;
			key_q   <= '0;
			txt_q   <= '0;
			fin_q   <= 1'b0;
			tl_q    <= '0;
			small_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			unique case (cmd.op)
				shbe_pkg::CMD_LOAD: begin
					if (first) begin
						h_q <= digest_size ? {64{8'h01}} : '0;
						n_q <= '0;
						s_q <= '0;
						wh_q <= digest_size ? {64{8'h01}} : '0;
						wn_q <= '0;
						ws_q <= '0;
					end else begin
						wh_q <= h_q;
						wn_q <= n_q;
						ws_q <= s_q;
					end
					m_q     <= mpad;
					txt_q   <= mpad;
					fin_q   <= final_req;
					tl_q    <= tail_length;
					small_q <= digest_size;
					idx_q   <= '0;
				end
				shbe_pkg::CMD_KEY: begin
					key_q <= lps_y;
					priority case (cmd.pass)
						shbe_pkg::PASS_CNT: txt_q <= wn_q;
						shbe_pkg::PASS_SUM: txt_q <= ws_q;
						default: ;
					endcase
					if (cmd.pass == shbe_pkg::PASS_CNT) m_q <= wn_q;
					if (cmd.pass == shbe_pkg::PASS_SUM) m_q <= ws_q;
				end
				shbe_pkg::CMD_TXT: txt_q <= lps_y;
				shbe_pkg::CMD_RKEY: key_q <= lps_y;
				shbe_pkg::CMD_FIN: begin
					if (cmd.pass == shbe_pkg::PASS_MSG && !fin_q) h_q <= h_q ^ txt_q ^ key_q ^ m_q;
					else wh_q <= h_cur ^ txt_q ^ key_q ^ m_q;
				end
				shbe_pkg::CMD_ADD: begin
					if (fin_q) begin
						wn_q <= add_y;
						ws_q <= sum_y;
					end else begin
						n_q <= add_y;
						s_q <= sum_y;
					end
				end
				shbe_pkg::CMD_NEXT: if (out_take) idx_q <= idx_q + 1'b1;
				default: ;
			endcase
		end
	end

	logic [2:0] sel;
	assign sel         = small_q ? (idx_q | 3'd4) : idx_q;
	assign digest_word = wh_q[64*sel +: 64];
	assign word_index  = small_q ? {1'b0, idx_q[1:0]} : idx_q;
	assign last        = small_q ? (idx_q[1:0] == 2'd3) : (idx_q == 3'd7);
	assign emit_done   = out_take && last;
	assign stat.is_final = fin_q;
endmodule

@@ bench/streebog_hash_engine_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// streebog_hash_engine_unit_test
// self-checking bench for the streebog 256/512 block hash engine
// ----------------------------------------------------------------------------
// blocks go in as stream beats in bursts with random gaps, digest words come
// out under a changing stall pattern; a scoreboard class keeps its own copy
// of the chain value, bit counter and checksum, predicts every digest word
// and compares each output beat with the oldest prediction
// ----------------------------------------------------------------------------

class digest_scoreboard;

	typedef struct {
		logic [63:0] word;
		logic [2:0]  idx;
		logic        last;
	} digest_beat_t;

	logic [7:0]   sbox [256];
	logic [63:0]  mix_rows [64];
	logic [63:0]  rcon [12][8];

	logic         small_digest;
	logic [511:0] chain;
	logic [511:0] length_bits;
	logic [511:0] sigma;

	digest_beat_t awaited [$];
	int           mismatches;
	int           digests;
	int           blocks;

	function new();
		sbox = '{
		8'hFC,8'hEE,8'hDD,8'h11,8'hCF,8'h6E,8'h31,8'h16,8'hFB,8'hC4,8'hFA,8'hDA,8'h23,8'hC5,8'h04,8'h4D,
		8'hE9,8'h77,8'hF0,8'hDB,8'h93,8'h2E,8'h99,8'hBA,8'h17,8'h36,8'hF1,8'hBB,8'h14,8'hCD,8'h5F,8'hC1,
		8'hF9,8'h18,8'h65,8'h5A,8'hE2,8'h5C,8'hEF,8'h21,8'h81,8'h1C,8'h3C,8'h42,8'h8B,8'h01,8'h8E,8'h4F,
		8'h05,8'h84,8'h02,8'hAE,8'hE3,8'h6A,8'h8F,8'hA0,8'h06,8'h0B,8'hED,8'h98,8'h7F,8'hD4,8'hD3,8'h1F,
		8'hEB,8'h34,8'h2C,8'h51,8'hEA,8'hC8,8'h48,8'hAB,8'hF2,8'h2A,8'h68,8'hA2,8'hFD,8'h3A,8'hCE,8'hCC,
		8'hB5,8'h70,8'h0E,8'h56,8'h08,8'h0C,8'h76,8'h12,8'hBF,8'h72,8'h13,8'h47,8'h9C,8'hB7,8'h5D,8'h87,
		8'h15,8'hA1,8'h96,8'h29,8'h10,8'h7B,8'h9A,8'hC7,8'hF3,8'h91,8'h78,8'h6F,8'h9D,8'h9E,8'hB2,8'hB1,
		8'h32,8'h75,8'h19,8'h3D,8'hFF,8'h35,8'h8A,8'h7E,8'h6D,8'h54,8'hC6,8'h80,8'hC3,8'hBD,8'h0D,8'h57,
		8'hDF,8'hF5,8'h24,8'hA9,8'h3E,8'hA8,8'h43,8'hC9,8'hD7,8'h79,8'hD6,8'hF6,8'h7C,8'h22,8'hB9,8'h03,
		8'hE0,8'h0F,8'hEC,8'hDE,8'h7A,8'h94,8'hB0,8'hBC,8'hDC,8'hE8,8'h28,8'h50,8'h4E,8'h33,8'h0A,8'h4A,
		8'hA7,8'h97,8'h60,8'h73,8'h1E,8'h00,8'h62,8'h44,8'h1A,8'hB8,8'h38,8'h82,8'h64,8'h9F,8'h26,8'h41,
		8'hAD,8'h45,8'h46,8'h92,8'h27,8'h5E,8'h55,8'h2F,8'h8C,8'hA3,8'hA5,8'h7D,8'h69,8'hD5,8'h95,8'h3B,
		8'h07,8'h58,8'hB3,8'h40,8'h86,8'hAC,8'h1D,8'hF7,8'h30,8'h37,8'h6B,8'hE4,8'h88,8'hD9,8'hE7,8'h89,
		8'hE1,8'h1B,8'h83,8'h49,8'h4C,8'h3F,8'hF8,8'hFE,8'h8D,8'h53,8'hAA,8'h90,8'hCA,8'hD8,8'h85,8'h61,
		8'h20,8'h71,8'h67,8'hA4,8'h2D,8'h2B,8'h09,8'h5B,8'hCB,8'h9B,8'h25,8'hD0,8'hBE,8'hE5,8'h6C,8'h52,
		8'h59,8'hA6,8'h74,8'hD2,8'hE6,8'hF4,8'hB4,8'hC0,8'hD1,8'h66,8'hAF,8'hC2,8'h39,8'h4B,8'h63,8'hB6};
		mix_rows = '{
		64'h8e20faa72ba0b470,64'h47107ddd9b505a38,64'had08b0e0c3282d1c,64'hd8045870ef14980e,
		64'h6c022c38f90a4c07,64'h3601161cf205268d,64'h1b8e0b0e798c13c8,64'h83478b07b2468764,
		64'ha011d380818e8f40,64'h5086e740ce47c920,64'h2843fd2067adea10,64'h14aff010bdd87508,
		64'h0ad97808d06cb404,64'h05e23c0468365a02,64'h8c711e02341b2d01,64'h46b60f011a83988e,
		64'h90dab52a387ae76f,64'h486dd4151c3dfdb9,64'h24b86a840e90f0d2,64'h125c354207487869,
		64'h092e94218d243cba,64'h8a174a9ec8121e5d,64'h4585254f64090fa0,64'haccc9ca9328a8950,
		64'h9d4df05d5f661451,64'hc0a878a0a1330aa6,64'h60543c50de970553,64'h302a1e286fc58ca7,
		64'h18150f14b9ec46dd,64'h0c84890ad27623e0,64'h0642ca05693b9f70,64'h0321658cba93c138,
		64'h86275df09ce8aaa8,64'h439da0784e745554,64'hafc0503c273aa42a,64'hd960281e9d1d5215,
		64'he230140fc0802984,64'h71180a8960409a42,64'hb60c05ca30204d21,64'h5b068c651810a89e,
		64'h456c34887a3805b9,64'hac361a443d1c8cd2,64'h561b0d22900e4669,64'h2b838811480723ba,
		64'h9bcf4486248d9f5d,64'hc3e9224312c8c1a0,64'heffa11af0964ee50,64'hf97d86d98a327728,
		64'he4fa2054a80b329c,64'h727d102a548b194e,64'h39b008152acb8227,64'h9258048415eb419d,
		64'h492c024284fbaec0,64'haa16012142f35760,64'h550b8e9e21f7a530,64'ha48b474f9ef5dc18,
		64'h70a6a56e2440598e,64'h3853dc371220a247,64'h1ca76e95091051ad,64'h0edd37c48a08a6d8,
		64'h07e095624504536c,64'h8d70c431ac02a736,64'hc83862965601dd1b,64'h641c314b2b8ee083};
		// lowest word first
		rcon = '{
		'{64'hdd806559f2a64507,64'h05767436cc744d23,64'ha2422a08a460d315,64'h4b7ce09192676901,
		  64'h714eb88d7585c4fc,64'h2f6a76432e45d016,64'hebcb2f81c0657c1f,64'hb1085bda1ecadae9},
		'{64'he679047021b19bb7,64'h55dda21bd7cbcd56,64'h5cb561c2db0aa7ca,64'h9ab5176b12d69958,
		  64'h61d55e0f16b50131,64'hf3feea720a232b98,64'h4fe39d460f70b5d7,64'h6fa3b58aa99d2f1a},
		'{64'h991e96f50aba0ab2,64'hc2b6f443867adb31,64'hc1c93a376062db09,64'hd3e20fe490359eb1,
		  64'hf2ea7514b1297b7b,64'h06f15e5f529c1f8b,64'h0a39fc286a3d8435,64'hf574dcac2bce2fc7},
		'{64'h220cbebc84e3d12e,64'h3453eaa193e837f1,64'hd8b71333935203be,64'ha9d72c82ed03d675,
		  64'h9d721cad685e353f,64'h488e857e335c3c7d,64'hf948e1a05d71e4dd,64'hef1fdfb3e81566d2},
		'{64'h601758fd7c6cfe57,64'h7a56a27ea9ea63f5,64'hdfff00b723271a16,64'hbfcd1747253af5a3,
		  64'h359e35d7800fffbd,64'h7f151c1f1686104a,64'h9a3f410c6ca92363,64'h4bea6bacad474799},
		'{64'hfa68407a46647d6e,64'hbf71c57236904f35,64'h0af21f66c2bec6b6,64'hcffaa6b71c9ab7b4,
		  64'h187f9ab49af08ec6,64'h2d66c4f95142a46c,64'h6fa4c33b7a3039c0,64'hae4faeae1d3ad3d9},
		'{64'h8886564d3a14d493,64'h3517454ca23c4af3,64'h06476983284a0504,64'h0992abc52d822c37,
		  64'hd3473e33197a93c9,64'h399ec6c7e6bf87c9,64'h51ac86febf240954,64'hf4c70e16eeaac5ec},
		'{64'ha47f0dd4bf02e71e,64'h36acc2355951a8d9,64'h69d18d2bd1a5c42f,64'hf4892bcb929b0690,
		  64'h89b4443b4ddbc49a,64'h4eb7f8719c36de1e,64'h03e7aa020c6e4141,64'h9b1f5b424d93c9a7},
		'{64'h7261445183235adb,64'h0e38dc92cb1f2a60,64'h7b2b8a9aa6079c54,64'h800a440bdbb2ceb1,
		  64'h3cd955b7e00d0984,64'h3a7d3a1b25894224,64'h944c9ad8ec165fde,64'h378f5a541631229b},
		'{64'h74b4c7fb98459ced,64'h3698fad1153bb6c3,64'h7a1e6c303b7652f4,64'h9fe76702af69334b,
		  64'h1fffe18a1b336103,64'h8941e71cff8a78db,64'h382ae548b2e4f3f3,64'habbedea680056f52},
		'{64'h6bcaa4cd81f32d1b,64'hdea2594ac06fd85d,64'hefbacd1d7d476e98,64'h8a1d71efea48b9ca,
		  64'h2001802114846679,64'hd8fa6bbbebab0761,64'h3002c6cd635afe94,64'h7bcd9ed0efc889fb},
		'{64'h48bc924af11bd720,64'hfaf417d5d9b21b99,64'he71da4aa88e12852,64'h5d80ef9d1891cc86,
		  64'hf82012d430219f9b,64'hcda43c32bcdf1d77,64'hd21380b00449b17a,64'h378ee767f11631ba}};
		small_digest = 1'b0;
		chain = '0;
		length_bits = '0;
		sigma = '0;
		mismatches = 0;
		digests = 0;
		blocks = 0;
	endfunction

	function logic [63:0] linear_layer(logic [63:0] v);
		logic [63:0] r;
		r = '0;
		for (int b = 0; b < 64; b++)
			if (v[b]) r ^= mix_rows[63 - b];
		return r;
	endfunction

	// substitution, byte transpose and linear layer on a xor b
	function logic [511:0] lps_mix(logic [511:0] a, logic [511:0] b);
		logic [511:0] x;
		logic [511:0] y;
		logic [63:0]  t;
		x = a ^ b;
		for (int i = 0; i < 8; i++) begin
			for (int j = 0; j < 8; j++)
				t[8*j +: 8] = sbox[x[64*j + 8*i +: 8]];
			y[64*i +: 64] = linear_layer(t);
		end
		return y;
	endfunction

	function logic [511:0] gost_compress(logic [511:0] h, logic [511:0] n, logic [511:0] m);
		logic [511:0] k;
		logic [511:0] txt;
		logic [511:0] c;
		k = lps_mix(h, n);
		txt = m;
		for (int r = 0; r < 12; r++) begin
			for (int w = 0; w < 8; w++)
				c[64*w +: 64] = rcon[r][w];
			txt = lps_mix(txt, k);
			k = lps_mix(k, c);
		end
		return h ^ txt ^ k ^ m;
	endfunction

	function void set_size(logic sz);
		small_digest = sz;
	endfunction

	// one accepted block: update the running state or queue the digest beats
	function void note_block(logic first, logic fin, logic [5:0] tail, logic [511:0] msg);
		logic [511:0] h;
		logic [511:0] n;
		logic [511:0] s;
		logic [511:0] m;
		int           cnt;
		int           base;
		blocks++;
		if (first) begin
			chain = small_digest ? {64{8'h01}} : '0;
			length_bits = '0;
			sigma = '0;
		end
		m = msg;
		if (!fin) begin
			chain = gost_compress(chain, length_bits, m);
			length_bits = length_bits + 512'd512;
			sigma = sigma + m;
			return;
		end
		// pad after the tail: one 0x01 byte then zeros
		for (int i = 0; i < 64; i++) begin
			if (i == tail) m[8*i +: 8] = 8'h01;
			else if (i > tail) m[8*i +: 8] = 8'h00;
		end
		h = gost_compress(chain, length_bits, m);
		n = length_bits + 512'(tail) * 512'd8;
		s = sigma + m;
		h = gost_compress(h, '0, n);
		h = gost_compress(h, '0, s);
		cnt = small_digest ? 4 : 8;
		base = small_digest ? 4 : 0;
		for (int i = 0; i < cnt; i++)
			awaited.push_back('{h[64*(base+i) +: 64], 3'(i), (i == cnt - 1)});
		digests++;
	endfunction

	function void check_word(logic [63:0] word, logic [2:0] idx, logic last);
		digest_beat_t e;
		if (awaited.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected digest beat word=%h idx=%0d last=%b", word, idx, last);
			return;
		end
		e = awaited.pop_front();
		if (word !== e.word || idx !== e.idx || last !== e.last) begin
			mismatches++;
			if (mismatches <= 10)
				$display("digest mismatch: expected %h/%0d/%b got %h/%0d/%b",
					e.word, e.idx, e.last, word, idx, last);
		end
	endfunction

	function int pending();
		return awaited.size();
	endfunction

endclass

module streebog_hash_engine_unit_test;

	localparam int CycleLimit = 600000;
	localparam int SettleCycles = 120;

	logic         clk;
	logic         arst_n;
	logic         cfg_valid;
	logic         cfg_ready;
	logic         cfg_data;
	logic         s_tvalid;
	logic         s_tready;
	logic [519:0] s_tdata;
	logic [1:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [71:0]  m_tdata;
	logic         m_tlast;

	digest_scoreboard sb;
	int cycles;
	int burst_left;
	int stall_pct;

	streebog_hash_engine_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// watchdog on the whole run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CycleLimit) begin
			$display("timeout after %0d cycles", cycles);
			$display("TEST FAILED");
			$finish;
		end
	end

	// receiver: stall density changes over the run, including none
	always @(posedge clk) begin
		if (cycles % 300 == 0) begin
			case ($urandom_range(0, 3))
				0: begin
					stall_pct <= 0;
				end
				1: begin
					stall_pct <= 25;
				end
				2: begin
					stall_pct <= 60;
				end
				default: begin
					stall_pct <= 90;
				end
			endcase
		end
		m_tready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// output monitor: every accepted digest beat goes to the scoreboard
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_word(m_tdata[63:0], m_tdata[66:64], m_tlast);
	end

	function automatic logic [63:0] rand_word();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic [511:0] rand_block();
		logic [511:0] b;
		for (int i = 0; i < 8; i++)
			b[64*i +: 64] = rand_word();
		return b;
	endfunction

	// one block beat; the burst ends with valid lowered and a random gap
	task automatic send_block(logic first, logic fin, logic [5:0] tail, logic [511:0] msg);
		s_tvalid <= 1'b1;
		s_tdata  <= {msg, tail};
		s_tuser  <= {fin, first};
		do @(posedge clk); while (!s_tready);
		sb.note_block(first, fin, tail, msg);
		burst_left--;
		if (burst_left <= 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? 30 : $urandom_range(1, 6);
		end
	endtask

	// sender holds off until every digest beat is in and the engine has settled
	task automatic drain();
		if (s_tvalid) s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_size(logic sz);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= sz;
		do @(posedge clk); while (!cfg_ready);
		sb.set_size(sz);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// a well-formed message: first block, some plain blocks, a padded tail
	task automatic send_message(int plain_blocks);
		logic [5:0] tail;
		tail = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 6'd63 : 6'd0)
			: 6'($urandom_range(0, 63));
		if (plain_blocks == 0) begin
			send_block(1'b1, 1'b1, tail, rand_block());
		end else begin
			send_block(1'b1, 1'b0, 6'($urandom), rand_block());
			for (int i = 1; i < plain_blocks; i++)
				send_block(1'b0, 1'b0, 6'($urandom), rand_block());
			send_block(1'b0, 1'b1, tail, rand_block());
		end
	endtask

	initial begin
		logic [511:0] garbage;
		int sent;
		int kind;
		sb = new();
		cycles = 0;
		burst_left = 3;
		stall_pct = 0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: 512-bit digest, empty and full tails
		write_size(1'b0);
		send_block(1'b1, 1'b1, 6'd0, '0);
		send_block(1'b1, 1'b1, 6'd63, '1);
		// all-ones blocks make the checksum wrap
		send_block(1'b1, 1'b0, 6'd0, '1);
		send_block(1'b0, 1'b0, 6'd63, '1);
		send_block(1'b0, 1'b1, 6'd32, '1);
		// bytes past the tail must be ignored
		garbage = rand_block();
		send_block(1'b1, 1'b1, 6'd5, garbage);
		// final without first reuses the stored state
		send_block(1'b0, 1'b1, 6'd17, rand_block());

		// directed: 256-bit digest
		write_size(1'b1);
		send_block(1'b1, 1'b1, 6'd0, '0);
		send_block(1'b1, 1'b1, 6'd63, '1);
		send_block(1'b1, 1'b0, 6'd9, rand_block());
		send_block(1'b0, 1'b1, 6'd0, rand_block());
		send_block(1'b0, 1'b1, 6'd40, rand_block());
		send_block(1'b1, 1'b0, 6'd0, rand_block());
		// size change inside an open message keeps the running state
		write_size(1'b0);
		send_block(1'b0, 1'b0, 6'd1, rand_block());
		send_block(1'b0, 1'b1, 6'd62, rand_block());

		// random phases, alternating digest size
		sent = 0;
		for (int phase = 0; phase < 6; phase++) begin
			write_size(phase[0] ? 1'b0 : 1'b1);
			for (int k = 0; k < 32; k = k) begin
				kind = $urandom_range(0, 9);
				if (kind < 7) begin
					int nb;
					nb = ($urandom_range(0, 1)) ? 0 : $urandom_range(1, 3);
					send_message(nb);
					k += nb + 1;
					sent += nb + 1;
				end else if (kind == 7) begin
					send_block(1'($urandom), 1'($urandom), 6'($urandom), rand_block());
					k++;
					sent++;
				end else begin
					send_block(1'b0, 1'b1, 6'($urandom), rand_block());
					k++;
					sent++;
				end
			end
		end

		drain();
		$display("blocks %0d, digests %0d across 512-bit and 256-bit settings",
			sb.blocks, sb.digests);
		$display("random part %0d blocks in 6 phases, tails 0..63, stalls 0..90%%", sent);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches, %0d beats missing", sb.mismatches, sb.pending());
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
